>>> hw/rtl/pft_pkg.sv
`timescale 1ns / 1ps
package pft_pkg;

    localparam int PFT_FRAC_BITS = 16;

    // radians to turns, 2^32 / (2*pi) in Q16 of the phase
    localparam logic signed [31:0] INV_TWO_PI = 32'sd683565276;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W = $clog2(CORDIC_STEPS);

    localparam int MUL_STEPS = 32;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    // |delta| * 1000 fits in 42 bits
    localparam int DIV_W = 42;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PHASE  = 6'b000010,
        ST_CORDIC = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    typedef struct packed {
        logic start;
        logic done;
    } unit_ctl_t;

    function automatic logic [31:0] pft_atan(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] pft_sat(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
        begin
            r = SAT_MAX;
        end
        else if (v < -40'sd2147483648)
        begin
            r = SAT_MIN;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/pft_if.sv
`timescale 1ns / 1ps
interface pft_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] angle;
    logic [31:0]        time_ms;

    modport source (output valid, cmd, pos_x, pos_y, angle, time_ms, input ready);
    modport sink (input valid, cmd, pos_x, pos_y, angle, time_ms, output ready);
endinterface

interface pft_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_heading;

    modport source (output valid, out_x, out_y, out_heading, vel_x, vel_y, vel_heading,
                    input ready);
    modport sink (input valid, out_x, out_y, out_heading, vel_x, vel_y, vel_heading,
                  output ready);
endinterface

>>> hw/rtl/pft_mul.sv
`timescale 1ns / 1ps
module pft_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  pft_pkg::unit_ctl_t  ctl_in,
    input  logic signed [31:0]  a,
    input  logic signed [31:0]  b,
    output logic                done,
    output logic signed [63:0]  prod
);
    import pft_pkg::*;

    logic signed [63:0]   mc_reg;
    logic [31:0]          mp_reg;
    logic signed [63:0]   acc_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 last;
    logic signed [63:0]   addend;

    assign last = (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1));

    // top multiplier bit carries negative weight
    always_comb
    begin
        if (!mp_reg[0])
        begin
            addend = 64'sd0;
        end
        else if (last)
        begin
            addend = -mc_reg;
        end
        else
        begin
            addend = mc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl_in.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.start)
        begin
            mc_reg  <= {{32{a[31]}}, a};
            mp_reg  <= b;
            acc_reg <= 64'sd0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + addend;
            mc_reg  <= mc_reg <<< 1;
            mp_reg  <= mp_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

    ap_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_in.start |-> !busy_reg) else $error("multiplier restarted while busy");
    ap_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("multiplier done without work");
    ap_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("multiplier done held");

endmodule

>>> hw/rtl/pft_cordic.sv
`timescale 1ns / 1ps
module pft_cordic (
    input  logic                clk,
    input  logic                rst_n,
    input  pft_pkg::unit_ctl_t  ctl_in,
    input  logic [31:0]         phase,
    output logic                done,
    output logic signed [31:0]  cos_v,
    output logic signed [31:0]  sin_v
);
    import pft_pkg::*;

    logic signed [33:0]  x_reg;
    logic signed [33:0]  y_reg;
    logic signed [32:0]  z_reg;
    logic [1:0]          quad_reg;
    logic [STEP_W-1:0]   i_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [31:0]         phase_rnd;
    logic [31:0]         rem;
    logic signed [33:0]  dx;
    logic signed [33:0]  dy;
    logic signed [32:0]  atan_v;
    logic signed [33:0]  neg_x;
    logic signed [33:0]  neg_y;
    logic                last;

    // nearest quarter turn, remainder within one eighth
    assign phase_rnd = phase + 32'h20000000;
    assign rem       = phase - {phase_rnd[31:30], 30'd0};
    assign dx        = y_reg >>> i_reg;
    assign dy        = x_reg >>> i_reg;
    assign atan_v    = {1'b0, pft_atan(i_reg)};
    assign last      = (i_reg == STEP_W'(CORDIC_STEPS - 1));
    assign neg_x     = -x_reg;
    assign neg_y     = -y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl_in.start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end
            else if (busy_reg)
            begin
                i_reg <= i_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= 34'sd0;
            z_reg    <= {rem[31], rem};
            quad_reg <= phase_rnd[31:30];
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_v;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_v;
            end
        end
    end

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cos_v = x_reg[31:0];
                sin_v = y_reg[31:0];
            end
            2'd1:
            begin
                cos_v = neg_y[31:0];
                sin_v = x_reg[31:0];
            end
            2'd2:
            begin
                cos_v = neg_x[31:0];
                sin_v = neg_y[31:0];
            end
            default:
            begin
                cos_v = y_reg[31:0];
                sin_v = neg_x[31:0];
            end
        endcase
    end

    assign done = done_reg;

    ap_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_in.start |-> !busy_reg) else $error("rotator restarted while busy");
    ap_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg) else $error("rotator done without work");
    ap_step_adv: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !ctl_in.start && !last |=> i_reg == $past(i_reg) + 1'b1)
        else $error("rotator step lost");

endmodule

>>> hw/rtl/pft_div.sv
`timescale 1ns / 1ps
module pft_div (
    input  logic                clk,
    input  logic                rst_n,
    input  pft_pkg::unit_ctl_t  ctl_in,
    input  logic [pft_pkg::DIV_W-1:0] num,
    input  logic [31:0]         den,
    output logic                done,
    output logic [pft_pkg::DIV_W-1:0] quo
);
    import pft_pkg::*;

    logic [DIV_W-1:0]     num_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [31:0]          rem_reg;
    logic [31:0]          den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [32:0]          trial;
    logic                 fits;
    logic [32:0]          diff;
    logic                 last;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, num_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});
    assign last  = (cnt_reg == DIV_CNT_W'(DIV_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl_in.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= 32'd0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? diff[31:0] : trial[31:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    ap_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_in.start |-> !busy_reg) else $error("divider restarted while busy");
    ap_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !$rose(busy_reg) |-> rem_reg < den_reg)
        else $error("divider remainder out of range");
    ap_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("divider done without work");

endmodule

>>> hw/rtl/pose_frame_transform_tracker_top.sv
`timescale 1ns / 1ps
// channel  dir  beat contents
// sample   in   cmd, pos_x, pos_y, angle, time_ms
// result   out  out_x, out_y, out_heading, vel_x, vel_y, vel_heading
//
// A set-pose beat goes straight to the result. A sample beat runs a phase
// multiply, the rotator, four serial products and, unless the elapsed time
// is zero, three rate divisions. Reset (rst_n, async) clears pose, offsets,
// rates and last time. The result register frees the core: the next sample
// is taken while a result waits for ready.
module pose_frame_transform_tracker_top #(
    parameter int FRAC_BITS = pft_pkg::PFT_FRAC_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    pft_in_if.sink     sample,
    pft_out_if.source  result
);
    import pft_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic               go_reg;
    logic               go_next;
    logic [1:0]         idx_reg;
    logic               cmd_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [31:0] pa_reg;
    logic [31:0]        time_reg;
    logic [31:0]        elapsed_reg;
    logic signed [31:0] off_x_reg;
    logic signed [31:0] off_y_reg;
    logic signed [31:0] off_h_reg;
    logic signed [31:0] pose_x_reg;
    logic signed [31:0] pose_y_reg;
    logic signed [31:0] pose_h_reg;
    logic signed [31:0] rate_x_reg;
    logic signed [31:0] rate_y_reg;
    logic signed [31:0] rate_h_reg;
    logic [31:0]        last_time_reg;
    logic signed [65:0] acc_reg;
    logic signed [31:0] nx_reg;
    logic signed [31:0] ny_reg;
    logic signed [31:0] nh_reg;
    logic               out_valid_reg;
    logic signed [31:0] o_x_reg;
    logic signed [31:0] o_y_reg;
    logic signed [31:0] o_h_reg;
    logic signed [31:0] o_vx_reg;
    logic signed [31:0] o_vy_reg;
    logic signed [31:0] o_vh_reg;

    logic               accept;
    logic               out_free;
    unit_ctl_t          mul_ctl;
    unit_ctl_t          cor_ctl;
    unit_ctl_t          div_ctl;
    logic               mul_done;
    logic               cor_done;
    logic               div_done;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_prod;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
    logic [DIV_W-1:0]   div_num;
    logic [DIV_W-1:0]   div_quo;
    logic signed [65:0] acc_sum;
    logic signed [65:0] acc_rnd;
    logic signed [65:0] acc_shr;
    logic signed [39:0] rot_off;
    logic signed [31:0] rot_sat;
    logic signed [31:0] rot_off_sel;
    logic signed [31:0] d_new;
    logic signed [31:0] d_old;
    logic signed [32:0] delta;
    logic               d_neg;
    logic [32:0]        d_mag;
    logic [DIV_W-1:0]   q_neg;
    logic signed [31:0] rate_val;

    assign accept   = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign sample.ready = (state_reg == ST_IDLE);

    // ---------------- units ----------------
    assign mul_ctl.start = go_reg && ((state_reg == ST_PHASE) || (state_reg == ST_MUL));
    assign cor_ctl.start = go_reg && (state_reg == ST_CORDIC);
    assign div_ctl.start = go_reg && (state_reg == ST_DIV);
    assign mul_ctl.done  = 1'b0;
    assign cor_ctl.done  = 1'b0;
    assign div_ctl.done  = 1'b0;

    always_comb
    begin
        if (state_reg == ST_PHASE)
        begin
            mul_a = INV_TWO_PI;
            mul_b = off_h_reg;
        end
        else
        begin
            case (idx_reg)
                2'd0:
                begin
                    mul_a = px_reg;
                    mul_b = cos_v;
                end
                2'd1:
                begin
                    mul_a = py_reg;
                    mul_b = sin_v;
                end
                2'd2:
                begin
                    mul_a = px_reg;
                    mul_b = sin_v;
                end
                default:
                begin
                    mul_a = py_reg;
                    mul_b = cos_v;
                end
            endcase
        end
    end

    pft_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (mul_ctl),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    pft_cordic u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (cor_ctl),
        .phase  (mul_prod[FRAC_BITS+31:FRAC_BITS]),
        .done   (cor_done),
        .cos_v  (cos_v),
        .sin_v  (sin_v)
    );

    // ---------------- rotated position ----------------
    always_comb
    begin
        case (idx_reg)
            2'd1:    acc_sum = acc_reg - {{2{mul_prod[63]}}, mul_prod};
            2'd3:    acc_sum = acc_reg + {{2{mul_prod[63]}}, mul_prod};
            default: acc_sum = {{2{mul_prod[63]}}, mul_prod};
        endcase
    end

    assign acc_rnd     = acc_sum + 66'sd536870912;
    assign acc_shr     = acc_rnd >>> 30;
    assign rot_off_sel = (idx_reg == 2'd1) ? off_x_reg : off_y_reg;
    assign rot_off     = acc_shr[39:0] + {{8{rot_off_sel[31]}}, rot_off_sel};
    assign rot_sat     = pft_sat(rot_off);

    // ---------------- rates ----------------
    always_comb
    begin
        case (idx_reg)
            2'd0:
            begin
                d_new = nx_reg;
                d_old = pose_x_reg;
            end
            2'd1:
            begin
                d_new = ny_reg;
                d_old = pose_y_reg;
            end
            default:
            begin
                d_new = nh_reg;
                d_old = pose_h_reg;
            end
        endcase
    end

    assign delta = {d_new[31], d_new} - {d_old[31], d_old};
    assign d_neg = delta[32];
    assign d_mag = d_neg ? 33'(-delta) : 33'(delta);
    // times 1000 as 1024 - 32 + 8
    assign div_num = {d_mag[31:0], 10'd0} - {5'd0, d_mag[31:0], 5'd0}
                   + {7'd0, d_mag[31:0], 3'd0};
    assign q_neg   = '0 - div_quo;

    always_comb
    begin
        if (d_neg)
        begin
            rate_val = (div_quo > DIV_W'(64'd2147483648)) ? SAT_MIN : q_neg[31:0];
        end
        else
        begin
            rate_val = (div_quo > DIV_W'(64'd2147483647)) ? SAT_MAX : div_quo[31:0];
        end
    end

    pft_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (div_ctl),
        .num    (div_num),
        .den    (elapsed_reg),
        .done   (div_done),
        .quo    (div_quo)
    );

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        go_next    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sample.cmd)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_PHASE;
                        go_next    = 1'b1;
                    end
                end
            end
            ST_PHASE:
            begin
                if (mul_done)
                begin
                    state_next = ST_CORDIC;
                    go_next    = 1'b1;
                end
            end
            ST_CORDIC:
            begin
                if (cor_done)
                begin
                    state_next = ST_MUL;
                    go_next    = 1'b1;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    go_next = 1'b1;
                    if (idx_reg == 2'd3)
                    begin
                        if (elapsed_reg != 32'd0)
                        begin
                            state_next = ST_DIV;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                            go_next    = 1'b0;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (idx_reg == 2'd2)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        go_next = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            idx_reg       <= 2'd0;
            off_x_reg     <= 32'sd0;
            off_y_reg     <= 32'sd0;
            off_h_reg     <= 32'sd0;
            pose_x_reg    <= 32'sd0;
            pose_y_reg    <= 32'sd0;
            pose_h_reg    <= 32'sd0;
            rate_x_reg    <= 32'sd0;
            rate_y_reg    <= 32'sd0;
            rate_h_reg    <= 32'sd0;
            last_time_reg <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;

            if (accept && sample.cmd)
            begin
                off_x_reg <= pft_sat(40'(off_x_reg) + 40'(sample.pos_x) - 40'(pose_x_reg));
                off_y_reg <= pft_sat(40'(off_y_reg) + 40'(sample.pos_y) - 40'(pose_y_reg));
                off_h_reg <= pft_sat(40'(off_h_reg) + 40'(sample.angle) - 40'(pose_h_reg));
            end

            if (state_reg == ST_CORDIC && cor_done)
            begin
                idx_reg <= 2'd0;
            end
            else if (state_reg == ST_MUL && mul_done)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            else if (state_reg == ST_DIV && div_done)
            begin
                idx_reg <= idx_reg + 1'b1;
                case (idx_reg)
                    2'd0:    rate_x_reg <= rate_val;
                    2'd1:    rate_y_reg <= rate_val;
                    default: rate_h_reg <= rate_val;
                endcase
            end

            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (!cmd_reg)
                begin
                    pose_x_reg    <= nx_reg;
                    pose_y_reg    <= ny_reg;
                    pose_h_reg    <= nh_reg;
                    last_time_reg <= time_reg;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= sample.cmd;
            px_reg      <= sample.pos_x;
            py_reg      <= sample.pos_y;
            pa_reg      <= sample.angle;
            time_reg    <= sample.time_ms;
            elapsed_reg <= sample.time_ms - last_time_reg;
        end
        if (state_reg == ST_MUL && mul_done)
        begin
            acc_reg <= acc_sum;
            if (idx_reg == 2'd1)
            begin
                nx_reg <= rot_sat;
            end
            if (idx_reg == 2'd3)
            begin
                ny_reg <= rot_sat;
                nh_reg <= pft_sat(40'(pa_reg) + 40'(off_h_reg));
            end
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            o_x_reg  <= cmd_reg ? pose_x_reg : nx_reg;
            o_y_reg  <= cmd_reg ? pose_y_reg : ny_reg;
            o_h_reg  <= cmd_reg ? pose_h_reg : nh_reg;
            o_vx_reg <= rate_x_reg;
            o_vy_reg <= rate_y_reg;
            o_vh_reg <= rate_h_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_x       = o_x_reg;
    assign result.out_y       = o_y_reg;
    assign result.out_heading = o_h_reg;
    assign result.vel_x       = o_vx_reg;
    assign result.vel_y       = o_vy_reg;
    assign result.vel_heading = o_vh_reg;

    ap_go_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        go_reg |=> !go_reg) else $error("unit start held");
    ap_mul_owner: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_PHASE) || (state_reg == ST_MUL))
        else $error("multiplier finished outside its steps");
    ap_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV) && (elapsed_reg != 32'd0))
        else $error("division finished outside rate steps");
    ap_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && out_free |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("result beat not loaded");

endmodule

>>> tb/tb_pft_checker.sv
`timescale 1ns / 1ps
module tb_pft_checker (
    input  logic      clk,
    input  logic      rst_n,
    pft_in_if.sink    sample_mon,
    pft_out_if.sink   result_mon,
    output int        fail_count,
    output int        pending
);
    import pft_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] heading;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vh;
    } pose_rec_t;

    longint off_x, off_y, off_h;
    longint cur_x, cur_y, cur_h;
    longint rt_x, rt_y, rt_h;
    logic [31:0] prev_ms;
    pose_rec_t pose_q[$];

    function automatic longint to_s32(longint v);
        logic signed [31:0] t;
        t = v[31:0];
        return longint'(t);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // the >>> on a signed longint is a floor shift
    function automatic void rotor(input longint ang, output longint c, output longint s);
        longint prod, z, rx, ry, dx, dy;
        logic [31:0] phase, quad, rem;
        logic [31:0] atan_t [30] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
            32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
        prod = ang * 64'sd683565276;
        phase = prod[47:16];
        quad = ((phase + 32'h20000000) >> 30) & 32'd3;
        rem = phase - (quad << 30);
        z = to_s32(longint'(rem));
        rx = 64'sd652032874;
        ry = 0;
        for (int i = 0; i < 30; i++)
        begin
            dx = ry >>> i;
            dy = rx >>> i;
            if (z >= 0)
            begin
                rx -= dx; ry += dy; z -= longint'(atan_t[i]);
            end
            else
            begin
                rx += dx; ry -= dy; z += longint'(atan_t[i]);
            end
        end
        case (quad)
            0: begin c = rx;  s = ry;  end
            1: begin c = -ry; s = rx;  end
            2: begin c = -rx; s = -ry; end
            default: begin c = ry; s = -rx; end
        endcase
    endfunction

    function automatic longint velocity(longint delta, logic [31:0] el);
        return clamp32((delta * 1000) / longint'({32'd0, el}));
    endfunction

    task automatic track_pose(logic cmd, longint px, longint py, longint pa,
                              logic [31:0] now);
        longint c, s, nx, ny, nh;
        logic [31:0] el;
        pose_rec_t r;
        if (cmd)
        begin
            off_x = clamp32(off_x + (px - cur_x));
            off_y = clamp32(off_y + (py - cur_y));
            off_h = clamp32(off_h + (pa - cur_h));
        end
        else
        begin
            rotor(off_h, c, s);
            nx = (px * c - py * s + (64'sd1 << 29)) >>> 30;
            ny = (px * s + py * c + (64'sd1 << 29)) >>> 30;
            nx = clamp32(nx + off_x);
            ny = clamp32(ny + off_y);
            nh = clamp32(pa + off_h);
            el = now - prev_ms;
            if (el != 0)
            begin
                rt_x = velocity(nx - cur_x, el);
                rt_y = velocity(ny - cur_y, el);
                rt_h = velocity(nh - cur_h, el);
            end
            cur_x = nx; cur_y = ny; cur_h = nh;
            prev_ms = now;
        end
        r.x = cur_x[31:0]; r.y = cur_y[31:0]; r.heading = cur_h[31:0];
        r.vx = rt_x[31:0]; r.vy = rt_y[31:0]; r.vh = rt_h[31:0];
        pose_q.push_back(r);
    endtask

    task automatic flag(string what, logic [31:0] exp_v, logic [31:0] got_v);
        if (fail_count < 10)
        begin
            $display("mismatch %s: expected %h got %h", what, exp_v, got_v);
        end
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        off_x = 0; off_y = 0; off_h = 0;
        cur_x = 0; cur_y = 0; cur_h = 0;
        rt_x = 0; rt_y = 0; rt_h = 0;
        prev_ms = '0;
    end

    assign pending = pose_q.size();

    always @(posedge clk)
    begin
        pose_rec_t e;
        if (rst_n)
        begin
            if (sample_mon.valid && sample_mon.ready)
            begin
                track_pose(sample_mon.cmd, longint'(sample_mon.pos_x),
                           longint'(sample_mon.pos_y), longint'(sample_mon.angle),
                           sample_mon.time_ms);
            end
            if (result_mon.valid && result_mon.ready)
            begin
                if (pose_q.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("result beat with nothing expected");
                    end
                    fail_count++;
                end
                else
                begin
                    e = pose_q.pop_front();
                    if (result_mon.out_x !== e.x) flag("out_x", e.x, result_mon.out_x);
                    if (result_mon.out_y !== e.y) flag("out_y", e.y, result_mon.out_y);
                    if (result_mon.out_heading !== e.heading)
                        flag("out_heading", e.heading, result_mon.out_heading);
                    if (result_mon.vel_x !== e.vx) flag("vel_x", e.vx, result_mon.vel_x);
                    if (result_mon.vel_y !== e.vy) flag("vel_y", e.vy, result_mon.vel_y);
                    if (result_mon.vel_heading !== e.vh)
                        flag("vel_heading", e.vh, result_mon.vel_heading);
                end
            end
        end
    end
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   stall_hold;
    bit   stim_done;
    logic [31:0] clock_ms;

    pft_in_if  sample_ch ();
    pft_out_if result_ch ();

    pose_frame_transform_tracker_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch.sink),
        .result (result_ch.source)
    );

    tb_pft_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_mon (sample_ch.sink),
        .result_mon (result_ch.sink),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 400);
    endfunction

    function automatic logic [31:0] wild32();
        logic [31:0] pick [6] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff,
                                  32'h1, 32'h80000001};
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return pick[$urandom_range(0, 5)];
        if (r < 6) return $urandom;
        return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh00ffffff;
    endfunction

    task automatic send(logic cmd, logic [31:0] px, logic [31:0] py,
                        logic [31:0] pa, logic [31:0] tms);
        sample_ch.valid   <= 1'b1;
        sample_ch.cmd     <= cmd;
        sample_ch.pos_x   <= px;
        sample_ch.pos_y   <= py;
        sample_ch.angle   <= pa;
        sample_ch.time_ms <= tms;
        do @(posedge clk); while (!sample_ch.ready);
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // result side: random ready, one long hold-off forced early on
    initial
    begin
        int g;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        while (1)
        begin
            @(posedge clk);
            if (stall_hold > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_hold--;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                g = gap_len();
                result_ch.ready <= (g == 0);
                stall_hold = g;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (1)
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 10000000)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] step;
        stall_hold = 0;
        stim_done = 0;
        clock_ms = '0;
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.cmd = 1'b0;
        sample_ch.pos_x = '0;
        sample_ch.pos_y = '0;
        sample_ch.angle = '0;
        sample_ch.time_ms = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero elapsed, extremes, set-pose, timer wrap, rate saturation
        send(1'b0, 32'h00010000, 32'h00020000, 32'h00008000, 32'd0);
        send(1'b0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'd1);
        send(1'b0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'd2);
        send(1'b1, 32'h00050000, 32'hfffb0000, 32'h0001921f, 32'hffffffff);
        send(1'b0, 32'h00010000, 32'h00010000, 32'h0, 32'd2);
        send(1'b1, 32'h0, 32'h0, 32'h00032440, 32'd0);
        send(1'b0, 32'h00030000, 32'hfffe0000, 32'h00010000, 32'd10);
        send(1'b1, 32'h0, 32'h0, 32'hfffcdbc0, 32'd0);
        send(1'b0, 32'h00030000, 32'h00040000, 32'h0, 32'hfffffffe);
        send(1'b0, 32'h00040000, 32'h00030000, 32'h0, 32'd3);
        send(1'b1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0);
        send(1'b1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h0);
        send(1'b0, 32'hffffffff, 32'h0, 32'h1, 32'hffffffff);
        send(1'b1, 32'h0, 32'h0, 32'h00024000, 32'h0);
        send(1'b0, 32'h12345678, 32'hedcba987, 32'h0, 32'hffffffff);
        send(1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
        clock_ms = 32'd0;

        // fill the block while the result side holds off
        stall_hold = 3000;
        for (int i = 0; i < 8; i++)
        begin
            clock_ms += $urandom_range(1, 20);
            send(1'b0, $urandom, $urandom, $urandom, clock_ms);
        end

        for (int i = 0; i < 1630; i++)
        begin
            idle_gap(gap_len());
            if ($urandom_range(0, 9) == 0)
            begin
                send(1'b1, wild32(), wild32(), wild32(), $urandom);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: step = 32'd0;
                    1: step = $urandom;
                    default: step = $urandom_range(1, 50);
                endcase
                clock_ms += step;
                send(1'b0, wild32(), wild32(), wild32(), clock_ms);
            end
        end
        sample_ch.valid <= 1'b0;
        stim_done = 1;

        do @(posedge clk); while (pending != 0);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
